[sv/kf_pkg.sv]
// ----------------------------------------------------------------------------
// kf_pkg
// Types, constants and command codes of the position/velocity Kalman filter.
// ----------------------------------------------------------------------------
package kf_pkg;
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int CFG_BITS  = 31;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int GAIN_BITS = WORD_BITS + FRAC_BITS + 2;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic signed [PROD_BITS-1:0] t_wide;

    localparam t_word FX_ONE  = t_word'(64'sd1 <<< FRAC_BITS);
    localparam t_word FX_MAX  = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word FX_MIN  = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        MODE_PREDICT = 2'd0,
        MODE_UPDATE  = 2'd1,
        MODE_INIT    = 2'd2,
        MODE_NONE    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_TIME_STEP = 2'd0,
        REG_POS_NOISE = 2'd1,
        REG_VEL_NOISE = 2'd2,
        REG_MEAS_NOISE = 2'd3
    } t_reg;

    // datapath micro-operations
    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,      // latch input word
        OP_INIT,      // load state from input, reset covariance
        OP_UPD_FIRST, // first update before ready
        OP_P_POS,     // pos += dt*vel
        OP_P_A,       // a = dt*sat(vp+pv)
        OP_P_DD,      // dd = dt*dt
        OP_P_B,       // b = dd*vv
        OP_P_C,       // c = dt*vv, commit predict
        OP_U_Y,       // y, s
        OP_U_DIV0,    // start k0 division
        OP_U_DIV1,    // start k1 division
        OP_U_POS,     // pos += k0*y
        OP_U_VEL,     // vel += k1*y
        OP_U_PP,      // t0 = g*pp
        OP_U_PV,      // t1 = g*pv
        OP_U_VP,      // t2 = k1*pp
        OP_U_VV,      // t3 = k1*pv, commit update
        OP_OUT        // capture result word
    } t_op;

    typedef struct packed {
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic ready;
    } t_status;

    function automatic t_word sat_wide(input t_wide v);
        if (v > t_wide'(FX_MAX)) return FX_MAX;
        if (v < t_wide'(FX_MIN)) return FX_MIN;
        return t_word'(v);
    endfunction
endpackage

[sv/kf_if.sv]
// ----------------------------------------------------------------------------
// kf_if
// Valid/ready channels: input word, result word and configuration write.
// ----------------------------------------------------------------------------
interface kf_in_if;
    import kf_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    t_word       measurement;
    t_word       start_velocity;
    modport source (output valid, mode, measurement, start_velocity, input ready);
    modport sink (input valid, mode, measurement, start_velocity, output ready);
endinterface

interface kf_out_if;
    import kf_pkg::*;
    logic  valid;
    logic  ready;
    t_word position;
    t_word velocity;
    logic  is_ready;
    modport source (output valid, position, velocity, is_ready, input ready);
    modport sink (input valid, position, velocity, is_ready, output ready);
endinterface

interface kf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[sv/kalman_filter_pos_vel.sv]
// ----------------------------------------------------------------------------
// kalman_filter_pos_vel
// Two-state constant-velocity Kalman filter, position measurements only.
// ----------------------------------------------------------------------------
// One word at a time, each mode stepping through its own sequence of datapath
// ops; a predict before the filter is ready goes straight to the result. The
// length of an update is set by the bit-serial gain divider (two gains, one
// after the other) and the single shared 32x32 multiplier. The next word is
// taken once the previous result has left the output register.
module kalman_filter_pos_vel
    import kf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    kf_in_if.sink     in_ch,
    kf_out_if.source  out_ch,
    kf_cfg_if.sink    cfg_ch
);
    t_cmd    w_cmd;
    t_status w_status;
    logic    w_load, w_in_ready;
    t_word   w_pos, w_vel;
    logic    w_rdy;

    assign in_ch.ready = w_in_ready;

    kf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_status   (w_status),
        .i_in_valid (in_ch.valid),
        .i_mode     (in_ch.mode),
        .o_in_ready (w_in_ready),
        .o_out_load (w_load),
        .i_out_free (!out_ch.valid || out_ch.ready),
        .o_cmd      (w_cmd)
    );

    kf_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .in_ch      (in_ch),
        .cfg_ch     (cfg_ch),
        .o_position (w_pos),
        .o_velocity (w_vel),
        .o_is_ready (w_rdy)
    );

    logic r_valid;
    t_word r_p, r_v;
    logic r_r;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (w_load) r_valid <= 1'b1;
        else if (out_ch.ready) r_valid <= 1'b0;
        if (w_load) begin
            r_p <= w_pos;
            r_v <= w_vel;
            r_r <= w_rdy;
        end
    end
    assign out_ch.valid = r_valid;
    assign out_ch.position = r_p;
    assign out_ch.velocity = r_v;
    assign out_ch.is_ready = r_r;
endmodule

[sv/kf_div.sv]
// ----------------------------------------------------------------------------
// kf_div
// Restoring divider, one quotient bit a cycle: (p << FRAC_BITS) / s, s > 0.
// ----------------------------------------------------------------------------
module kf_div
    import kf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  t_word                 i_num,
    input  logic [WORD_BITS:0]    i_den,
    output logic                  o_done,
    output t_word                 o_quot
);
    localparam int NB = WORD_BITS + FRAC_BITS;
    localparam int CB = $clog2(NB + 1);

    logic [NB-1:0]      r_num, n_num;
    logic [WORD_BITS:0] r_den;
    logic [WORD_BITS+1:0] r_rem, n_rem;
    logic [NB-1:0]      r_q, n_q;
    logic [CB-1:0]      r_cnt;
    logic               r_busy, r_neg;
    logic [WORD_BITS+1:0] w_try;
    logic [NB:0]        w_sq;

    always_comb begin
        w_try = {r_rem[WORD_BITS:0], r_num[NB-1]};
        n_num = r_num << 1;
        if (w_try >= {1'b0, r_den}) begin
            n_rem = w_try - {1'b0, r_den};
            n_q = {r_q[NB-2:0], 1'b1};
        end else begin
            n_rem = w_try;
            n_q = {r_q[NB-2:0], 1'b0};
        end
        w_sq = r_neg ? -{1'b0, r_q} : {1'b0, r_q};
        if (!r_neg && r_q > NB'(FX_MAX))
            o_quot = FX_MAX;
        else if (r_neg && r_q > NB'(FX_MAX) + NB'(1))
            o_quot = FX_MIN;
        else
            o_quot = t_word'(w_sq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= CB'(NB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CB'(1);
                if (r_cnt == CB'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[WORD_BITS-1];
            r_num <= {(i_num[WORD_BITS-1] ? -i_num : i_num), {FRAC_BITS{1'b0}}};
            r_den <= i_den;
            r_rem <= '0;
            r_q <= '0;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
            r_q <= n_q;
        end
    end
endmodule

[sv/kf_datapath.sv]
// ----------------------------------------------------------------------------
// kf_datapath
// State registers, one shared multiplier with registered product, divider.
// ----------------------------------------------------------------------------
module kf_datapath
    import kf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    kf_in_if.sink       in_ch,
    kf_cfg_if.sink      cfg_ch,
    output t_word       o_position,
    output t_word       o_velocity,
    output logic        o_is_ready
);
    logic [CFG_BITS-1:0] r_dt, r_qp, r_qv, r_r;
    t_word r_pos, r_vel, r_pp, r_pv, r_vp, r_vv;
    logic  r_ready;
    t_word r_z, r_v0;
    t_word r_y, r_k0, r_k1, r_a, r_b, r_dd, r_mul;
    logic  r_spos;
    logic  r_div_k1;
    logic [WORD_BITS:0] r_s;
    t_word w_ma, w_mb, w_mul, w_quot, w_g;
    t_wide w_prod;
    logic  w_div_start, w_div_done;
    t_word w_num;

    assign cfg_ch.ready = 1'b1;
    assign o_status.ready = r_ready;
    assign o_status.div_done = w_div_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= CFG_BITS'(FX_ONE);
            r_qp <= '0;
            r_qv <= '0;
            r_r <= CFG_BITS'(FX_ONE);
        end else if (cfg_ch.valid) begin
            case (cfg_ch.index)
                REG_TIME_STEP:  r_dt <= cfg_ch.data[CFG_BITS-1:0];
                REG_POS_NOISE:  r_qp <= cfg_ch.data[CFG_BITS-1:0];
                REG_VEL_NOISE:  r_qv <= cfg_ch.data[CFG_BITS-1:0];
                REG_MEAS_NOISE: r_r <= cfg_ch.data[CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign w_g = sat_wide(t_wide'(FX_ONE) - t_wide'(r_k0));

    // operand select for the multiplier of the current op
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.op)
            OP_P_POS: begin w_ma = t_word'({1'b0, r_dt}); w_mb = r_vel; end
            OP_P_A: begin
                w_ma = t_word'({1'b0, r_dt});
                w_mb = sat_wide(t_wide'(r_vp) + t_wide'(r_pv));
            end
            OP_P_DD: begin w_ma = t_word'({1'b0, r_dt}); w_mb = t_word'({1'b0, r_dt}); end
            OP_P_B: begin w_ma = w_mul; w_mb = r_vv; end
            OP_P_C: begin w_ma = t_word'({1'b0, r_dt}); w_mb = r_vv; end
            OP_U_POS: begin w_ma = r_k0; w_mb = r_y; end
            OP_U_VEL: begin w_ma = r_k1; w_mb = r_y; end
            OP_U_PP: begin w_ma = w_g; w_mb = r_pp; end
            OP_U_PV: begin w_ma = w_g; w_mb = r_pv; end
            OP_U_VP: begin w_ma = r_k1; w_mb = r_pp; end
            OP_U_VV: begin w_ma = r_k1; w_mb = r_pv; end
            default: ;
        endcase
    end

    // each op multiplies and the result lands in r_mul; the op one later consumes it
    assign w_prod = t_wide'(w_ma) * t_wide'(w_mb);
    assign w_mul = r_mul;

    assign w_div_start = (i_cmd.op == OP_U_DIV0) || (i_cmd.op == OP_U_DIV1);
    assign w_num = (i_cmd.op == OP_U_DIV0) ? r_pp : r_vp;

    kf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start && r_spos),
        .i_num   (w_num),
        .i_den   (r_s),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    logic [4:0] r_last;
    always_ff @(posedge i_clk) begin
        r_mul <= sat_wide(w_prod >>> FRAC_BITS);
        r_last <= i_cmd.op;
        if (in_ch.valid && in_ch.ready) begin
            r_z <= in_ch.measurement;
            r_v0 <= in_ch.start_velocity;
        end
        if (w_div_start) r_div_k1 <= (i_cmd.op == OP_U_DIV1);
        if (i_cmd.op == OP_U_Y) begin
            r_k0 <= '0;
            r_k1 <= '0;
        end else if (w_div_done) begin
            if (r_div_k1) r_k1 <= w_quot;
            else r_k0 <= w_quot;
        end
    end

    // results of the previous op, applied as the next op issues
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
            r_pos <= '0;
            r_vel <= '0;
            r_pp <= FX_ONE;
            r_pv <= '0;
            r_vp <= '0;
            r_vv <= FX_ONE;
        end else begin
            case (t_op'(r_last))
                OP_P_POS: r_pos <= sat_wide(t_wide'(r_pos) + t_wide'(w_mul));
                OP_P_A: r_a <= w_mul;
                OP_P_DD: r_dd <= w_mul;
                OP_P_B: r_b <= w_mul;
                OP_P_C: begin
                    r_pp <= sat_wide(t_wide'(r_pp) + t_wide'(r_a) + t_wide'(r_b)
                            + t_wide'({1'b0, r_qp}));
                    r_pv <= sat_wide(t_wide'(r_pv) + t_wide'(w_mul));
                    r_vp <= sat_wide(t_wide'(r_vp) + t_wide'(w_mul));
                    r_vv <= sat_wide(t_wide'(r_vv) + t_wide'({1'b0, r_qv}));
                end
                OP_U_POS: r_pos <= sat_wide(t_wide'(r_pos) + t_wide'(w_mul));
                OP_U_VEL: r_vel <= sat_wide(t_wide'(r_vel) + t_wide'(w_mul));
                OP_U_PP: r_a <= w_mul;
                OP_U_PV: r_b <= w_mul;
                OP_U_VP: r_dd <= w_mul;
                OP_U_VV: begin
                    r_pp <= r_a;
                    r_pv <= r_b;
                    r_vp <= sat_wide(t_wide'(r_vp) - t_wide'(r_dd));
                    r_vv <= sat_wide(t_wide'(r_vv) - t_wide'(w_mul));
                end
                default: ;
            endcase
            case (i_cmd.op)
                OP_INIT, OP_UPD_FIRST: begin
                    r_pos <= r_z;
                    r_vel <= (i_cmd.op == OP_INIT) ? r_v0 : '0;
                    r_pp <= FX_ONE;
                    r_pv <= '0;
                    r_vp <= '0;
                    r_vv <= FX_ONE;
                    r_ready <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_U_Y) begin
            r_y <= sat_wide(t_wide'(r_z) - t_wide'(r_pos));
            r_s <= (WORD_BITS+1)'(r_pp) + (WORD_BITS+1)'({1'b0, r_r});
            r_spos <= ($signed({r_pp[WORD_BITS-1], r_pp}) + $signed({2'b0, r_r})) > 0;
        end else if (i_cmd.op == OP_U_DIV0) begin
            r_spos <= r_spos && ($signed(r_s) > 0);
        end
    end

    assign o_position = r_pos;
    assign o_velocity = r_vel;
    assign o_is_ready = r_ready;
endmodule

[sv/kf_ctrl.sv]
// ----------------------------------------------------------------------------
// kf_ctrl
// Sequencer: accepts a word, steps the datapath ops, hands off the result.
// ----------------------------------------------------------------------------
module kf_ctrl
    import kf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    input  logic    i_in_valid,
    input  logic [1:0] i_mode,
    output logic    o_in_ready,
    output logic    o_out_load,
    input  logic    i_out_free,
    output t_cmd    o_cmd
);
    t_op  r_state, n_state;
    logic [1:0] r_mode;
    logic [5:0] r_wait;
    logic r_divs;

    always_comb begin
        n_state = r_state;
        case (r_state)
            OP_NOP: if (i_in_valid && i_out_free) n_state = OP_LOAD;
            OP_LOAD: begin
                case (r_mode)
                    MODE_PREDICT: n_state = i_status.ready ? OP_P_POS : OP_OUT;
                    MODE_UPDATE:  n_state = i_status.ready ? OP_U_Y : OP_UPD_FIRST;
                    MODE_INIT:    n_state = OP_INIT;
                    default:      n_state = OP_OUT;
                endcase
            end
            OP_INIT, OP_UPD_FIRST: n_state = OP_OUT;
            OP_P_POS: n_state = OP_P_A;
            OP_P_A:   n_state = OP_P_DD;
            OP_P_DD:  n_state = OP_P_B;
            OP_P_B:   n_state = OP_P_C;
            OP_P_C:   n_state = OP_OUT;
            OP_U_Y:   n_state = OP_U_DIV0;
            OP_U_DIV0: if (r_wait == 6'd0) n_state = OP_U_DIV1;
            OP_U_DIV1: if (r_wait == 6'd0) n_state = OP_U_POS;
            OP_U_POS: n_state = OP_U_VEL;
            OP_U_VEL: n_state = OP_U_PP;
            OP_U_PP:  n_state = OP_U_PV;
            OP_U_PV:  n_state = OP_U_VP;
            OP_U_VP:  n_state = OP_U_VV;
            OP_U_VV:  n_state = OP_OUT;
            OP_OUT:   n_state = OP_NOP;
            default:  n_state = OP_NOP;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == OP_NOP) && i_out_free;
        o_out_load = (r_state == OP_OUT);
        o_cmd.op = r_state;
        // divide ops issue the start only on their first cycle
        if ((r_state == OP_U_DIV0 || r_state == OP_U_DIV1) && r_divs)
            o_cmd.op = OP_NOP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= OP_NOP;
            r_wait <= '0;
            r_divs <= 1'b0;
            r_mode <= MODE_NONE;
        end else begin
            if (i_in_valid && o_in_ready) r_mode <= i_mode;
            r_state <= n_state;
            if (n_state != r_state) begin
                r_divs <= 1'b0;
                r_wait <= 6'(WORD_BITS + FRAC_BITS + 1);
            end else begin
                r_divs <= 1'b1;
                if (r_wait != 6'd0) r_wait <= r_wait - 6'd1;
            end
        end
    end
endmodule

[sv/kf_checker.sv]
// ----------------------------------------------------------------------------
// kf_checker
// Port-level checks of the filter handshakes.
// ----------------------------------------------------------------------------
module kf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_is_ready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready) else $error("second word taken");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |-> !in_ready) else $error("taken while blocked");
    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_ready && out_is_ready ##1 out_valid |-> out_is_ready)
        else $error("ready flag cleared");
endmodule

bind kalman_filter_pos_vel kf_checker u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_is_ready (out_ch.is_ready)
);

[dv/kf_tb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kf_tb_if
// Testbench-side note: channel interfaces come from the RTL interface file.
// ----------------------------------------------------------------------------
package kf_tb_pkg;
    import kf_pkg::*;

    typedef struct packed {
        t_word position;
        t_word velocity;
        logic  is_ready;
    } t_estimate;
endpackage

[dv/tb_kalman_filter_pos_vel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kalman_filter_pos_vel
// Drives predict, update, initialize and unused-mode words and register writes
// through the filter with random idling and output stalls, predicts each
// estimate with a fixed-point model and checks every result word per field.
// ----------------------------------------------------------------------------
module tb_kalman_filter_pos_vel;
    import kf_pkg::*;
    import kf_tb_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    kf_in_if  in_ch();
    kf_out_if out_ch();
    kf_cfg_if cfg_ch();

    kalman_filter_pos_vel DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .cfg_ch  (cfg_ch.sink)
    );

    always #10 i_clk = ~i_clk;

    // filter model state
    longint dt_q, qp_q, qv_q, r_q;
    bit     m_ready;
    longint m_pos, m_vel, m_pp, m_pv, m_vp, m_vv;

    t_estimate estimate_q[$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  hold_off = 0;
    bit  no_idle = 0;

    localparam longint ONE = 64'sd65536;
    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;

    function automatic longint fx_sat(longint v);
        if (v > WMAX) return WMAX;
        if (v < WMIN) return WMIN;
        return v;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        return fx_sat((a * b) >>> 16);
    endfunction

    function automatic longint fx_gain(longint p, longint s);
        if (s <= 0) return 0;
        return fx_sat((p * ONE) / s);
    endfunction

    task automatic cov_to_reset();
        m_pp = ONE; m_pv = 0; m_vp = 0; m_vv = ONE;
    endtask

    task automatic model_reset();
        dt_q = ONE; qp_q = 0; qv_q = 0; r_q = ONE;
        m_ready = 0; m_pos = 0; m_vel = 0;
        cov_to_reset();
    endtask

    task automatic predict_estimate(t_mode mode, t_word z, t_word v0);
        longint a, b, y, s, k0, k1, g, npp, npv, nvp, nvv;
        t_estimate e;
        case (mode)
            MODE_PREDICT: if (m_ready) begin
                m_pos = fx_sat(m_pos + fx_mul(dt_q, m_vel));
                a = fx_mul(dt_q, fx_sat(m_vp + m_pv));
                b = fx_mul(fx_mul(dt_q, dt_q), m_vv);
                npp = fx_sat(m_pp + a + b + qp_q);
                npv = fx_sat(m_pv + fx_mul(dt_q, m_vv));
                nvp = fx_sat(m_vp + fx_mul(dt_q, m_vv));
                nvv = fx_sat(m_vv + qv_q);
                m_pp = npp; m_pv = npv; m_vp = nvp; m_vv = nvv;
            end
            MODE_UPDATE: if (!m_ready) begin
                m_pos = z; m_vel = 0; cov_to_reset(); m_ready = 1;
            end else begin
                y = fx_sat(longint'(z) - m_pos);
                s = m_pp + r_q;
                k0 = fx_gain(m_pp, s);
                k1 = fx_gain(m_vp, s);
                m_pos = fx_sat(m_pos + fx_mul(k0, y));
                m_vel = fx_sat(m_vel + fx_mul(k1, y));
                g = fx_sat(ONE - k0);
                npp = fx_mul(g, m_pp);
                npv = fx_mul(g, m_pv);
                nvp = fx_sat(m_vp - fx_mul(k1, m_pp));
                nvv = fx_sat(m_vv - fx_mul(k1, m_pv));
                m_pp = npp; m_pv = npv; m_vp = nvp; m_vv = nvv;
            end
            MODE_INIT: begin
                m_pos = z; m_vel = v0; cov_to_reset(); m_ready = 1;
            end
            default: ;
        endcase
        e.position = t_word'(m_pos);
        e.velocity = t_word'(m_vel);
        e.is_ready = m_ready;
        estimate_q.push_back(e);
    endtask

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < 34);
    endfunction

    task automatic send_word(t_mode mode, t_word z, t_word v0);
        while (idle_now()) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.mode           <= mode;
        in_ch.measurement    <= z;
        in_ch.start_velocity <= v0;
        predict_estimate(mode, z, v0);
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (estimate_q.size() != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg idx, logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        case (idx)
            REG_TIME_STEP:  dt_q = value[30:0];
            REG_POS_NOISE:  qp_q = value[30:0];
            REG_VEL_NOISE:  qv_q = value[30:0];
            REG_MEAS_NOISE: r_q  = value[30:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [31:0] dt, logic [31:0] qp, logic [31:0] qv,
                            logic [31:0] r);
        drain();
        write_reg(REG_TIME_STEP, dt);
        write_reg(REG_POS_NOISE, qp);
        write_reg(REG_VEL_NOISE, qv);
        write_reg(REG_MEAS_NOISE, r);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic t_word rand_small();
        return t_word'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
    endfunction

    function automatic t_word rand_word();
        case ($urandom_range(3))
            0: return rand_small();
            1: return t_word'($urandom);
            2: return $urandom_range(1) ? FX_MAX : FX_MIN;
            default: return t_word'($signed($urandom_range(0, 32'h0400_0000))
                                    - 32'sh0200_0000);
        endcase
    endfunction

    task automatic test_directed();
        send_word(MODE_PREDICT, 32'sd0, 32'sd0);
        send_word(MODE_NONE, FX_MAX, FX_MIN);
        send_word(MODE_UPDATE, 32'sh0003_0000, FX_MAX);
        send_word(MODE_PREDICT, 32'sd0, 32'sd0);
        send_word(MODE_UPDATE, 32'sh0004_8000, 32'sd0);
        send_word(MODE_INIT, FX_MAX, FX_MIN);
        send_word(MODE_UPDATE, FX_MIN, 32'sd0);
        send_word(MODE_INIT, FX_MIN, FX_MAX);
        send_word(MODE_PREDICT, 32'sd0, 32'sd0);
        send_word(MODE_UPDATE, FX_MAX, 32'sd0);
        send_word(MODE_NONE, 32'sd0, 32'sd0);
        send_word(MODE_INIT, 32'sd0, 32'sh0001_0000);
        set_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(MODE_PREDICT, 32'sd0, 32'sd0);
        send_word(MODE_PREDICT, 32'sd0, 32'sd0);
        send_word(MODE_UPDATE, 32'sh1234_5678, 32'sd0);
        set_regs(32'h0, 32'h0, 32'h0, 32'h0);
        send_word(MODE_INIT, 32'sh0001_0000, -32'sh0001_0000);
        send_word(MODE_PREDICT, 32'sd0, 32'sd0);
        send_word(MODE_UPDATE, 32'sh0002_0000, 32'sd0);
        send_word(MODE_UPDATE, -32'sh0002_0000, 32'sd0);
    endtask

    // zero measurement noise collapses the position covariance, making the innovation variance non-positive
    task automatic test_negative_variance();
        set_regs(32'h0002_0000, 32'h0, 32'h0, 32'h0);
        send_word(MODE_INIT, 32'sd0, 32'sh0001_0000);
        send_word(MODE_UPDATE, 32'sh0001_0000, 32'sd0);
        repeat (6) send_word(MODE_UPDATE, rand_word(), 32'sd0);
        send_word(MODE_PREDICT, 32'sd0, 32'sd0);
        send_word(MODE_UPDATE, rand_word(), 32'sd0);
    endtask

    task automatic test_random(int count);
        t_mode m;
        for (int i = 0; i < count; i++) begin
            if (i % 150 == 0) begin
                case ((i / 150) % 4)
                    0: set_regs($urandom_range(0, 32'h0002_0000),
                                $urandom_range(0, 32'h0001_0000),
                                $urandom_range(0, 32'h0000_4000),
                                $urandom_range(0, 32'h0004_0000));
                    1: set_regs($urandom, $urandom, $urandom, $urandom);
                    2: set_regs(32'h0000_4000, 32'h0000_0100, 32'h0000_0100,
                                32'h0001_0000);
                    default: set_regs($urandom_range(0, 32'h0001_0000), 32'h0,
                                      32'h0, $urandom_range(0, 32'h0000_1000));
                endcase
                no_idle = ((i / 150) == 3);
            end
            if (i % 60 == 0) begin
                send_word(MODE_INIT, rand_word(), rand_word());
                continue;
            end
            case ($urandom_range(19))
                0:        m = MODE_NONE;
                1:        m = MODE_INIT;
                2,3,4,5,6,7,8,9: m = MODE_PREDICT;
                default:  m = MODE_UPDATE;
            endcase
            send_word(m, rand_word(), rand_word());
        end
        no_idle = 0;
    endtask

    task automatic test_backpressure();
        hold_off = 1;
        fork
            begin
                repeat (400) @(negedge i_clk);
                hold_off = 0;
            end
            repeat (8) send_word(MODE_PREDICT, 32'sd0, 32'sd0);
        join
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_estimate exp_e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (estimate_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word p=%h v=%h r=%b",
                    out_ch.position, out_ch.velocity, out_ch.is_ready);
            end else begin
                exp_e = estimate_q.pop_front();
                if (out_ch.position !== exp_e.position || out_ch.velocity !== exp_e.velocity
                    || out_ch.is_ready !== exp_e.is_ready) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp p=%h v=%h r=%b got p=%h v=%h r=%b",
                            exp_e.position, exp_e.velocity, exp_e.is_ready,
                            out_ch.position, out_ch.velocity, out_ch.is_ready);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= !hold_off && !idle_now();
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_PREDICT;
        in_ch.measurement = '0;
        in_ch.start_velocity = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_TIME_STEP;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        model_reset();
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_negative_variance();
        test_backpressure();
        test_random(1000);
        drain();
        if (mismatches == 0 && estimate_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
